@@ rtl/tsp_pkg.sv @@
// tsp_pkg: shared constants and helpers for the table-shuffle PRNG fold block.
// No dependencies.
package tsp_pkg;
  localparam int TableEntries = 256;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int WordW        = 32;
  localparam logic [WordW-1:0] MixStep  = 32'h06a0dd9b;
  localparam logic [WordW-1:0] ShufStep = 32'h9e3779b7;

  localparam logic FuncStart   = 1'b0;
  localparam logic FuncAdvance = 1'b1;

  // Rotate left; amount taken mod 32, zero is identity.
  function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] x,
                                               input logic [4:0] s);
    logic [2*WordW-1:0] d;
    begin
      d = {x, x} << s;
      rotl32 = d[2*WordW-1:WordW];
    end
  endfunction
endpackage

@@ rtl/tsp_ram.sv @@
// tsp_ram: single-port table memory, 256 x 32, registered read.
// Depends on tsp_pkg.
module tsp_ram import tsp_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IdxW-1:0]  addr,
  input  logic [WordW-1:0] wdata,
  output logic [WordW-1:0] rdata
);
  logic [WordW-1:0] mem [TableEntries];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/tsp_round.sv @@
// tsp_round: one rotate-and-mix round, split over a few sequencer steps,
// plus a 32x9 scale multiply. Depends on tsp_pkg.
module tsp_round import tsp_pkg::*; (
  input  logic             clk,
  input  logic [2:0]       step,    // 0..4
  input  logic             en,
  input  logic [WordW-1:0] base,
  input  logic [WordW-1:0] w_in,
  input  logic [IdxW-1:0]  idx,
  input  logic             load,    // load a,b,c at fold start
  input  logic [WordW-1:0] a_init,
  input  logic [WordW-1:0] b_init,
  output logic [IdxW-1:0]  pick
);
  logic [WordW-1:0] a_r, b_r, c_r, w_r;
  logic [WordW-1:0] a_new, b_new, w_new, c_rot;
  logic [WordW+IdxW:0] prod;

  assign a_new = rotl32(b_r ^ w_in, c_r[4:0]) ^ (base + a_r);
  assign b_new = rotl32(base + a_r, idx[4:0]) ^ (w_in + c_r);
  assign w_new = (rotl32(a_r ^ w_in, idx[4:0]) << 9) ^ (b_r >> 18);
  assign c_rot = rotl32(((w_r + c_r) << 14) ^ (b_r >> 13) ^ a_r, b_r[4:0]);
  assign prod  = c_r * ({1'b0, idx} + 9'd1);
  assign pick  = c_r[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      a_r <= a_init;
      b_r <= b_init;
      c_r <= '0;
    end else if (en) begin
      unique case (step)
        3'd0: a_r <= a_new;
        3'd1: b_r <= b_new;
        3'd2: w_r <= w_new;
        3'd3: c_r <= c_rot;
        3'd4: c_r <= WordW'(prod >> WordW);   // scale into 0..idx
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/table_shuffle_prng_fold_top.sv @@
// table_shuffle_prng_fold_top: top level and sequencer of the PRNG fold.
// Depends on tsp_pkg, tsp_ram, tsp_round.
//
// Usage: in_func=0 loads the seed and refills both 256-word tables from
// their linear patterns (one table word per cycle in each of two
// single-port RAMs); the item returns the seed. in_func=1 runs one fold:
// 255 rounds (mix-table reads for the window, 5 round steps through the
// shared round unit, 4 shuffle-table accesses for the swap), then 256
// table XORs and a hash of 8 lanes (2 index reads and 32 block reads per
// lane); the work is serialised by the single read port of each table.
// After reset the block runs the same refill as a start with seed 0,
// returns no item for it, and is not ready until it finishes. in_ready
// is low while an item is in work; the result sits in an output register
// until taken, and the next item is accepted the same cycle the register
// empties.
module table_shuffle_prng_fold_top import tsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_func,
  input  logic [WordW-1:0] in_seed,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_value
);
  localparam logic [3:0] S_IDLE = 4'd0, S_FILL = 4'd1, S_WIN = 4'd2,
    S_RND = 4'd3, S_SW0 = 4'd4, S_SW1 = 4'd5, S_SW2 = 4'd6, S_SW3 = 4'd7,
    S_XR0 = 4'd8, S_XR1 = 4'd9, S_HL = 4'd10, S_HB = 4'd11, S_DONE = 4'd12;

  logic [3:0]       st_r;
  logic [IdxW:0]    k_r;      // fill / xor / block counter; lane during S_HL
  logic [3:0]       e_r;      // window / lane sub-counter
  logic [2:0]       rs_r;     // round step
  logic [IdxW-1:0]  idx_r;
  logic [WordW-1:0] run_r, cnt_r, w_r, acc_r, res_r, tmp_r, out_r;
  logic [WordW-1:0] res_nxt;
  logic             out_v_r, busy_r, boot_r;

  logic             m_we, s_we;
  logic [IdxW-1:0]  m_addr, s_addr, pick;
  logic [WordW-1:0] m_wd, s_wd, m_rd, s_rd;
  logic             rnd_en, rnd_load;

  tsp_ram u_mix (.clk, .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));
  tsp_ram u_shf (.clk, .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));

  tsp_round u_rnd (.clk, .step(rs_r), .en(rnd_en), .base(run_r), .w_in(w_r),
    .idx(idx_r), .load(rnd_load), .a_init(run_r), .b_init(cnt_r), .pick(pick));

  assign in_ready  = !busy_r && (!out_v_r || out_ready);
  assign out_valid = out_v_r;
  assign out_value = out_r;
  assign rnd_load  = (st_r == S_IDLE);
  assign rnd_en    = (st_r == S_RND);

  // hash accumulator after folding in the last block word of this lane
  assign res_nxt   = res_r ^ ((acc_r ^ m_rd) << e_r[2:0]);

  // Memory port control. Window reads: e_r 0..7 issues, 1..8 captures.
  // Hash: each lane reads mix[lane], then mix[that], then 32 block words.
  always_comb begin
    logic [IdxW:0] kp1;
    kp1    = k_r + 1'b1;
    m_we   = 1'b0;
    s_we   = 1'b0;
    m_addr = k_r[IdxW-1:0];
    s_addr = k_r[IdxW-1:0];
    m_wd   = WordW'(kp1) * MixStep;
    s_wd   = WordW'(kp1) * ShufStep;
    unique case (st_r)
      S_FILL: begin m_we = 1'b1; s_we = 1'b1; end
      S_WIN:  m_addr = idx_r + IdxW'(e_r);
      S_SW0:  s_addr = idx_r;
      S_SW1:  s_addr = pick;
      S_SW2:  begin s_addr = idx_r; s_we = 1'b1; s_wd = s_rd; end
      S_SW3:  begin s_addr = pick;  s_we = 1'b1; s_wd = tmp_r; end
      S_XR0:  ;
      S_XR1:  begin m_we = 1'b1; m_wd = m_rd ^ s_rd; end
      S_HL:   m_addr = (e_r == 4'd1) ? m_rd[IdxW-1:0] : IdxW'(k_r[2:0]);
      S_HB:   m_addr = {k_r[IdxW-4:0], e_r[2:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_FILL; k_r <= '0; busy_r <= 1'b1; boot_r <= 1'b1; out_v_r <= 1'b0;
      run_r <= '0; cnt_r <= '0; e_r <= '0; rs_r <= '0;
    end else begin
      unique case (st_r)
        // a finished result only waits while idle
        S_IDLE: begin
          if (out_ready) out_v_r <= 1'b0;
          if (in_valid && in_ready) begin
            busy_r <= 1'b1;
            k_r <= '0; e_r <= '0;
            if (in_func == FuncStart) begin
              run_r <= in_seed; cnt_r <= '0; st_r <= S_FILL;
            end else begin
              idx_r <= IdxW'(TableEntries - 1); w_r <= '0; st_r <= S_WIN;
            end
          end
        end
        // refill; a start item returns the seed, the refill after reset returns no item
        S_FILL: begin
          if (k_r == (IdxW+1)'(TableEntries - 1)) begin
            k_r <= '0;
            if (boot_r) begin
              boot_r <= 1'b0; busy_r <= 1'b0; st_r <= S_IDLE;
            end else begin
              out_r <= run_r; st_r <= S_DONE;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_WIN: begin
          if (e_r != 4'd0) w_r <= w_r ^ (m_rd << (e_r - 4'd1));
          if (e_r == 4'd8) begin
            e_r <= '0; rs_r <= '0; st_r <= S_RND;
          end else begin
            e_r <= e_r + 4'd1;
          end
        end
        S_RND: begin
          rs_r <= rs_r + 3'd1;
          if (rs_r == 3'd4) st_r <= S_SW0;
        end
        S_SW0: st_r <= S_SW1;
        S_SW1: begin tmp_r <= s_rd; st_r <= S_SW2; end
        S_SW2: st_r <= S_SW3;
        S_SW3: begin
          if (idx_r == IdxW'(1)) begin k_r <= '0; st_r <= S_XR0; end
          else begin idx_r <= idx_r - 1'b1; w_r <= '0; st_r <= S_WIN; end
        end
        S_XR0: st_r <= S_XR1;
        S_XR1: begin
          if (k_r == (IdxW+1)'(TableEntries - 1)) begin
            k_r <= '0; e_r <= '0; res_r <= '0; st_r <= S_HL;
          end else begin
            k_r <= k_r + 1'b1; st_r <= S_XR0;
          end
        end
        // k_r holds lane; e_r: 0 read mix[lane]; 1 read mix[mix[lane]]; 2 capture acc
        S_HL: begin
          if (e_r == 4'd2) begin
            acc_r <= m_rd; e_r <= {1'b0, k_r[2:0]}; k_r <= '0; st_r <= S_HB;
          end else begin
            e_r <= e_r + 4'd1;
          end
        end
        // Block pass: e_r holds lane, k_r counts blocks 0..32 (captures trail reads)
        S_HB: begin
          if (k_r == (IdxW+1)'(TableEntries / 8)) begin
            res_r <= res_nxt;
            if (e_r[2:0] == 3'd7) begin
              out_r <= res_nxt;
              run_r <= res_nxt;
              cnt_r <= cnt_r + 1'b1;
              st_r <= S_DONE;
            end else begin
              k_r <= (IdxW+1)'(e_r[2:0]) + 1'b1; e_r <= '0; st_r <= S_HL;
            end
          end else begin
            if (k_r != '0) acc_r <= acc_r ^ m_rd;
            k_r <= k_r + 1'b1;
          end
        end
        S_DONE: if (!out_v_r || out_ready) begin
          out_v_r <= 1'b1; busy_r <= 1'b0; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/tsp_checker.sv @@
// tsp_checker: port-level assertions for table_shuffle_prng_fold_top, with bind.
// Depends on tsp_pkg.
module tsp_checker import tsp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WordW-1:0] out_value
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result before item worked");
  a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while result waits");
endmodule

bind table_shuffle_prng_fold_top tsp_checker u_chk (.clk, .rst_n, .in_valid,
  .in_ready, .out_valid, .out_ready, .out_value);

@@ bench/table_shuffle_prng_fold_top_tb.sv @@
// Testbench for table_shuffle_prng_fold_top: directed and random start/advance items
// checked against an in-bench predictor of the tables, running value and count.
// Depends on tsp_pkg and the RTL of the block.
module table_shuffle_prng_fold_top_tb;
  import tsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 100000;
  localparam int MaxShown   = 10;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_func;
  logic [WordW-1:0] in_seed;
  logic             out_valid;
  logic             out_ready;
  logic [WordW-1:0] out_value;

  table_shuffle_prng_fold_top DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_seed,
    .out_valid, .out_ready, .out_value
  );

  // predictor state
  logic [WordW-1:0] shuf_tbl [TableEntries];
  logic [WordW-1:0] mix_tbl  [TableEntries];
  logic [WordW-1:0] run_val;
  logic [WordW-1:0] fold_cnt;

  logic [WordW-1:0] value_q [$];   // expected out_value per accepted item
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int results_seen;
  int starts_sent;
  int folds_sent;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [WordW-1:0] rot_left(logic [WordW-1:0] x, logic [WordW-1:0] amt);
    logic [4:0] s;
    s = amt[4:0];
    if (s == 0) return x;
    return (x << s) | (x >> (6'd32 - s));
  endfunction

  function automatic void load_tables(logic [WordW-1:0] seed);
    for (int k = 0; k < TableEntries; k++) begin
      mix_tbl[k]  = (k + 1) * MixStep;
      shuf_tbl[k] = (k + 1) * ShufStep;
    end
    run_val  = seed;
    fold_cnt = '0;
  endfunction

  function automatic logic [WordW-1:0] hash_tables();
    logic [WordW-1:0] res;
    logic [WordW-1:0] acc;
    res = '0;
    for (int lane = 0; lane < 8; lane++) begin
      acc = mix_tbl[mix_tbl[lane][IdxW-1:0]];
      for (int blk = 0; blk < TableEntries / 8; blk++)
        acc ^= mix_tbl[(blk * 8 + lane) % TableEntries];
      res ^= acc << lane;
    end
    return res;
  endfunction

  // one fold: 255 shuffle rounds, table XOR, hash into the running value
  function automatic void fold_once();
    logic [WordW-1:0] base, a, b, c, w, t;
    logic [63:0]      prod;
    logic [IdxW-1:0]  pick;
    base = run_val;
    a    = base;
    b    = fold_cnt;
    c    = '0;
    for (int idx = TableEntries - 1; idx > 0; idx--) begin
      w = '0;
      for (int e = 0; e < 8; e++)
        w ^= mix_tbl[(idx + e) % TableEntries] << e;
      a = rot_left(b ^ w, c) ^ (base + a);
      b = rot_left(base + a, idx) ^ (w + c);
      w = (rot_left(a ^ w, idx) << 9) ^ (b >> 18);
      c = rot_left(((w + c) << 14) ^ (b >> 13) ^ a, b);
      prod = {32'd0, c} * (idx + 1);
      c = prod[63:32];
      pick = c[IdxW-1:0];
      t = shuf_tbl[idx];
      shuf_tbl[idx]  = shuf_tbl[pick];
      shuf_tbl[pick] = t;
    end
    for (int k = 0; k < TableEntries; k++)
      mix_tbl[k] ^= shuf_tbl[k];
    run_val  = hash_tables();
    fold_cnt = fold_cnt + 1;
  endfunction

  // send one item; predict once the handshake completes
  task automatic send_item(logic func, logic [WordW-1:0] seed);
    while ($urandom_range(99) < send_idle_pct)
      @(negedge clk);
    in_valid = 1'b1;
    in_func  = func;
    in_seed  = seed;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (func == FuncStart) begin
      load_tables(seed);
      starts_sent++;
    end else begin
      fold_once();
      folds_sent++;
    end
    value_q.push_back(run_val);
    @(negedge clk);
    in_valid = 1'b0;
    in_seed  = $urandom;
  endtask

  // receiver stalls
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (value_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("unexpected result value=%08h", out_value);
      end else begin
        if (out_value !== value_q[0]) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("value mismatch: expected %08h got %08h", value_q[0], out_value);
        end
        void'(value_q.pop_front());
      end
    end
  end

  // watchdog: no handshake for too long ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // extremes of seed, advance straight after reset, back-to-back folds
  task automatic test_directed();
    send_item(FuncAdvance, 32'h0);           // fold from the reset state
    send_item(FuncAdvance, 32'hffff_ffff);   // seed ignored on advance
    send_item(FuncStart, 32'h0);
    send_item(FuncAdvance, 32'h0);
    send_item(FuncStart, 32'hffff_ffff);
    send_item(FuncAdvance, 32'h0);
    send_item(FuncAdvance, 32'h0);
    send_item(FuncStart, 32'haaaa_aaaa);
    send_item(FuncAdvance, 32'h5555_5555);
    send_item(FuncStart, 32'h5555_5555);
    send_item(FuncStart, 32'h8000_0000);
    send_item(FuncAdvance, 32'h0);
    send_item(FuncStart, 32'h0000_0001);
    send_item(FuncAdvance, 32'h0);
    send_item(FuncAdvance, 32'h0);
    send_item(FuncAdvance, 32'h0);
  endtask

  // mostly a start followed by a few folds; some lone items as noise
  task automatic test_random(int n_items);
    int sent;
    int folds;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        send_item(FuncStart, $urandom);
        folds = $urandom_range(2);
        for (int f = 0; f < folds; f++)
          send_item(FuncAdvance, $urandom);
        sent += folds + 1;
      end else begin
        send_item(logic'($urandom_range(1)), $urandom);
        sent++;
      end
    end
  endtask

  // wait for outstanding results, then return on a falling edge
  task automatic drain();
    while (value_q.size() != 0)
      @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = FuncStart;
    in_seed       = '0;
    send_idle_pct = 20;
    recv_idle_pct = 76;
    mismatches    = 0;
    results_seen  = 0;
    starts_sent   = 0;
    folds_sent    = 0;
    load_tables('0);                         // reset acts as start with seed 0
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(115);
    drain();
    send_idle_pct = 76;
    recv_idle_pct = 20;
    test_random(115);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(115);
    drain();

    $display("covered %0d starts and %0d folds, %0d results checked, %0d mismatches",
             starts_sent, folds_sent, results_seen, mismatches);
    if (mismatches == 0 && value_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/tsp_pkg.sv
rtl/tsp_ram.sv
rtl/tsp_round.sv
rtl/table_shuffle_prng_fold_top.sv
rtl/tsp_checker.sv
bench/table_shuffle_prng_fold_top_tb.sv
